>>> rtl/tlt_pkg.sv
// Shared types, constants and register map of the tilt orientation qualifier.
package tlt_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TIME_W       = 32;
    localparam int PROD_W       = SAMPLE_WIDTH + 10;
    localparam int IN_TDATA_W   = ((TIME_W + 2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IN_PAD_W     = IN_TDATA_W - TIME_W - 2 * SAMPLE_WIDTH;
    localparam int OUT_TDATA_W  = 8;

    // register map, index into paddr[3:2]
    localparam logic [1:0] REG_TILT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_AXIS_MARGIN    = 2'd1;
    localparam logic [1:0] REG_POLL_INTERVAL  = 2'd2;
    localparam logic [1:0] REG_STABLE_TIME    = 2'd3;

    localparam logic [14:0] TILT_THRESHOLD_RST = 15'd4096;
    localparam logic [9:0]  AXIS_MARGIN_RST    = 10'd320;
    localparam logic [15:0] POLL_INTERVAL_RST  = 16'd100;
    localparam logic [15:0] STABLE_TIME_RST    = 16'd300;

    typedef struct packed {
        logic [14:0] tilt_level;
        logic [9:0]  axis_margin_q8;
        logic [15:0] poll_interval_ms;
        logic [15:0] hold_ms;
    } tlt_cfg_t;

    typedef struct packed {
        logic       ambiguous;
        logic [1:0] quadrant;
    } tlt_class_t;

    typedef struct packed {
        logic [1:0] quadrant;
        logic       changed;
    } tlt_result_t;

endpackage

>>> rtl/tilt_orientation_qualifier_core.sv
// Top level: stream ports, APB register file, input and result registers.
// Path: input register, then result register, from the edge that accepts an input
// transaction to the first edge that can accept its result. Throughput: one transaction
// per cycle while m_tready is high. m_tready low holds the result register; the input
// register takes one more transaction while the result waits, then s_tready drops.
// Async reset: pipeline empty, state zero, registers 4096 / 320 / 100 ms / 300 ms.
module tilt_orientation_qualifier_core
    import tlt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // now_ms, accel_x, accel_y (low to high)
    input  logic                   s_tuser,   // sample_ok
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // quadrant, zero pad
    output logic                   m_tuser,   // changed
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    tlt_cfg_t cfg_reg;

    logic                           in_valid_reg;
    logic [TIME_W-1:0]              in_now_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_y_reg;
    logic                           in_ok_reg;

    logic        out_valid_reg;
    tlt_result_t out_res_reg;

    logic        advance;
    logic        fire;
    logic        cfg_wr;
    tlt_class_t  cls;
    tlt_result_t res;

    // ---------------------------------------------------------------
    // APB register file, no wait states
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tilt_level       <= TILT_THRESHOLD_RST;
            cfg_reg.axis_margin_q8   <= AXIS_MARGIN_RST;
            cfg_reg.poll_interval_ms <= POLL_INTERVAL_RST;
            cfg_reg.hold_ms          <= STABLE_TIME_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TILT_THRESHOLD: cfg_reg.tilt_level       <= pwdata[14:0];
                REG_AXIS_MARGIN:    cfg_reg.axis_margin_q8   <= pwdata[9:0];
                REG_POLL_INTERVAL:  cfg_reg.poll_interval_ms <= pwdata[15:0];
                REG_STABLE_TIME:    cfg_reg.hold_ms          <= pwdata[15:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TILT_THRESHOLD: prdata = 32'(cfg_reg.tilt_level);
            REG_AXIS_MARGIN:    prdata = 32'(cfg_reg.axis_margin_q8);
            REG_POLL_INTERVAL:  prdata = 32'(cfg_reg.poll_interval_ms);
            REG_STABLE_TIME:    prdata = 32'(cfg_reg.hold_ms);
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline flow: the work stage moves whenever the result register
    // is empty or is being drained this cycle.
    // ---------------------------------------------------------------
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_now_reg <= s_tdata[TIME_W-1:0];
            in_x_reg   <= s_tdata[TIME_W +: SAMPLE_WIDTH];
            in_y_reg   <= s_tdata[TIME_W + SAMPLE_WIDTH +: SAMPLE_WIDTH];
            in_ok_reg  <= s_tuser;
        end
    end

    // ---------------------------------------------------------------
    // Work stage: classify, then poll gate and stable-time qualifier
    // ---------------------------------------------------------------
    tlt_classify u_classify (
        .accel_x (in_x_reg),
        .accel_y (in_y_reg),
        .cfg     (cfg_reg),
        .cls     (cls)
    );

    tlt_qualify u_qualify (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .now_ms    (in_now_reg),
        .sample_ok (in_ok_reg),
        .cls       (cls),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2)'(0), out_res_reg.quadrant};
    assign m_tuser  = out_res_reg.changed;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full and stalled");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed transaction did not reach the result register");
`endif

endmodule

>>> rtl/tlt_classify.sv
// Quadrant classification of one X/Y accelerometer sample.
module tlt_classify
    import tlt_pkg::*;
(
    input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  tlt_cfg_t                       cfg,
    output tlt_class_t                     cls
);

    logic                    neg_x;
    logic                    neg_y;
    logic [SAMPLE_WIDTH-1:0] mag_x;
    logic [SAMPLE_WIDTH-1:0] mag_y;
    logic [PROD_W-1:0]       ext_x;
    logic [PROD_W-1:0]       ext_y;
    logic [PROD_W-1:0]       thresh;
    logic [PROD_W-1:0]       y_scaled;
    logic [PROD_W-1:0]       x_scaled;
    logic [PROD_W-1:0]       y_times_m;
    logic [PROD_W-1:0]       x_times_m;
    logic                    below;

    // most negative input maps to 2^(W-1), which fits as unsigned
    assign neg_x = accel_x[SAMPLE_WIDTH-1];
    assign neg_y = accel_y[SAMPLE_WIDTH-1];
    assign mag_x = neg_x ? (~accel_x + 1'b1) : accel_x;
    assign mag_y = neg_y ? (~accel_y + 1'b1) : accel_y;

    assign ext_x  = PROD_W'(mag_x);
    assign ext_y  = PROD_W'(mag_y);
    assign thresh = PROD_W'(cfg.tilt_level);

    assign y_scaled  = {2'b00, mag_y, 8'h00};
    assign x_scaled  = {2'b00, mag_x, 8'h00};
    assign x_times_m = ext_x * PROD_W'(cfg.axis_margin_q8);
    assign y_times_m = ext_y * PROD_W'(cfg.axis_margin_q8);

    assign below = (ext_x < thresh) && (ext_y < thresh);

    always_comb
    begin
        cls.ambiguous = 1'b0;
        cls.quadrant  = 2'd0;
        priority if (below)
        begin
            cls.ambiguous = 1'b1;
        end
        else if (y_scaled > x_times_m)
        begin
            cls.quadrant = (!neg_y && (mag_y != '0)) ? 2'd3 : 2'd1;
        end
        else if (x_scaled > y_times_m)
        begin
            cls.quadrant = (!neg_x && (mag_x != '0)) ? 2'd0 : 2'd2;
        end
        else
        begin
            cls.ambiguous = 1'b1;
        end
    end

endmodule

>>> rtl/tlt_qualify.sv
// Poll gating and stable-time qualification state of the orientation.
module tlt_qualify
    import tlt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              sample_ok,
    input  tlt_class_t        cls,
    input  tlt_cfg_t          cfg,
    output tlt_result_t       res
);

    logic [1:0]        committed_reg;
    logic [1:0]        committed_next;
    logic [1:0]        pending_reg;
    logic [1:0]        pending_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [TIME_W-1:0] poll_elapsed;
    logic [TIME_W-1:0] hold_elapsed;
    logic              poll_ok;
    logic              hold_ok;
    logic              changed;

    assign poll_elapsed = now_ms - last_reg;
    assign hold_elapsed = now_ms - start_reg;
    assign poll_ok = poll_elapsed >= TIME_W'(cfg.poll_interval_ms);
    assign hold_ok = hold_elapsed >= TIME_W'(cfg.hold_ms);

    always_comb
    begin
        committed_next = committed_reg;
        pending_next   = pending_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        changed        = 1'b0;
        if (fire && poll_ok)
        begin
            last_next = now_ms;
            if (sample_ok)
            begin
                priority if (cls.ambiguous || (cls.quadrant == committed_reg))
                begin
                    pending_next = committed_reg;
                end
                else if (cls.quadrant != pending_reg)
                begin
                    pending_next = cls.quadrant;
                    start_next   = now_ms;
                end
                else if (hold_ok)
                begin
                    committed_next = cls.quadrant;
                    changed        = 1'b1;
                end
                else
                begin
                    // candidate still settling
                    pending_next = pending_reg;
                end
            end
        end
    end

    assign res.quadrant = committed_next;
    assign res.changed  = changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= 2'd0;
            pending_reg   <= 2'd0;
            start_reg     <= '0;
            last_reg      <= '0;
        end
        else
        begin
            committed_reg <= committed_next;
            pending_reg   <= pending_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
        end
    end

`ifndef ASSERT_OFF
    a_commit_only_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (committed_reg != $past(committed_reg)) |-> $past(fire && res.changed))
        else $error("committed quadrant moved without a change flag");

    a_commit_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.changed) |=> (committed_reg == $past(pending_reg)))
        else $error("commit did not take the pending quadrant");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tilt orientation qualifier core.
module tb_top;
    import tlt_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction of any kind
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 6;     // slack after the last result returns
    localparam int PHASE_ITEMS    = 400;
    localparam int PRINT_LIMIT    = 20;

    // display quadrants as the classifier numbers them
    localparam logic [1:0] QUAD_X_POS = 2'd0;
    localparam logic [1:0] QUAD_Y_NEG = 2'd1;
    localparam logic [1:0] QUAD_X_NEG = 2'd2;
    localparam logic [1:0] QUAD_Y_POS = 2'd3;

    // kinds of generated readings beyond the four tilted ones
    localparam int KIND_FLAT  = 4;
    localparam int KIND_NOISE = 5;

    typedef struct {
        logic [31:0]             now_ms;
        logic [SAMPLE_WIDTH-1:0] accel_x;
        logic [SAMPLE_WIDTH-1:0] accel_y;
        logic                    ok;
    } sample_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;    // now_ms, accel_x, accel_y (low to high)
    logic                   s_tuser  = 1'b0;  // sample_ok
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // quadrant, zero pad
    logic                   m_tuser;          // changed
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [3:0]             paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Predictor copy of the registers and the qualifier state
    tlt_cfg_t    cfg;
    logic [1:0]  cur_quadrant;
    logic [1:0]  cand_quadrant;
    logic [31:0] cand_since_ms;
    logic [31:0] last_sample_ms;

    tlt_result_t orient_due_q[$];   // expected results, oldest first

    // Stimulus knobs, set by the test tasks
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_left   = 0;
    logic [31:0] stamp_ms       = '0;

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned commits_seen  = 0;
    int unsigned config_writes = 0;
    int unsigned quiet_cycles  = 0;

    tilt_orientation_qualifier_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Quadrant of one reading, or ambiguous. Magnitudes are exact, so the
    // most negative count gives one more than full-scale positive.
    function automatic tlt_class_t classify_tilt(logic [SAMPLE_WIDTH-1:0] x,
                                                 logic [SAMPLE_WIDTH-1:0] y);
        logic [SAMPLE_WIDTH:0] mag_x;
        logic [SAMPLE_WIDTH:0] mag_y;
        tlt_class_t            cls;
        mag_x = x[SAMPLE_WIDTH-1] ? -{1'b1, x} : {1'b0, x};
        mag_y = y[SAMPLE_WIDTH-1] ? -{1'b1, y} : {1'b0, y};
        cls.ambiguous = 1'b0;
        cls.quadrant  = QUAD_X_POS;
        if (mag_x < cfg.tilt_level && mag_y < cfg.tilt_level)
            cls.ambiguous = 1'b1;
        // Y is tested first, so it wins when a margin below 1.0 lets both pass
        else if (64'(mag_y) * 64'd256 > 64'(mag_x) * 64'(cfg.axis_margin_q8))
            cls.quadrant = (!y[SAMPLE_WIDTH-1] && mag_y != 0) ? QUAD_Y_POS : QUAD_Y_NEG;
        else if (64'(mag_x) * 64'd256 > 64'(mag_y) * 64'(cfg.axis_margin_q8))
            cls.quadrant = (!x[SAMPLE_WIDTH-1] && mag_x != 0) ? QUAD_X_POS : QUAD_X_NEG;
        else
            cls.ambiguous = 1'b1;
        return cls;
    endfunction

    // Advances the qualifier by one accepted transaction, returns its result.
    function automatic tlt_result_t qualify_sample(sample_t smp);
        tlt_class_t  cls;
        tlt_result_t res;
        res.changed = 1'b0;
        // early samples (wrapping difference) leave everything untouched
        if (smp.now_ms - last_sample_ms >= 32'(cfg.poll_interval_ms))
        begin
            last_sample_ms = smp.now_ms;
            // a failed read only moves the poll timestamp
            if (smp.ok)
            begin
                cls = classify_tilt(smp.accel_x, smp.accel_y);
                if (cls.ambiguous || cls.quadrant == cur_quadrant)
                    cand_quadrant = cur_quadrant;
                else if (cls.quadrant != cand_quadrant)
                begin
                    cand_quadrant = cls.quadrant;
                    cand_since_ms = smp.now_ms;
                end
                else if (smp.now_ms - cand_since_ms >= 32'(cfg.hold_ms))
                begin
                    cur_quadrant = cls.quadrant;
                    res.changed  = 1'b1;
                end
            end
        end
        res.quadrant = cur_quadrant;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Next timestamp: mostly one poll interval plus jitter, sometimes too
    // early, sometimes a large jump that may wrap.
    function automatic logic [31:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8 && cfg.poll_interval_ms != 0)
            stamp_ms = stamp_ms + $urandom_range(cfg.poll_interval_ms - 1);
        else if (pick < 11)
            stamp_ms = stamp_ms + $urandom;
        else
            stamp_ms = stamp_ms + cfg.poll_interval_ms
                       + $urandom_range(cfg.hold_ms / 3 + 4);
        return stamp_ms;
    endfunction

    // One reading of the given kind: a tilted quadrant, flat, or noise.
    function automatic sample_t make_reading(int kind, logic [31:0] now);
        sample_t                 smp;
        int                      major;
        int                      minor;
        int                      flat_lim;
        logic [SAMPLE_WIDTH-1:0] maj_v;
        logic [SAMPLE_WIDTH-1:0] min_v;
        smp.now_ms = now;
        smp.ok     = ($urandom_range(99) >= 7);
        major      = $urandom_range(32767, cfg.tilt_level);
        minor      = $urandom_range(major / 5);
        maj_v      = SAMPLE_WIDTH'(major);
        min_v      = $urandom_range(1) ? SAMPLE_WIDTH'(-minor) : SAMPLE_WIDTH'(minor);
        // negative-axis quadrants take the negated major, now and then full scale
        if (kind == QUAD_X_NEG || kind == QUAD_Y_NEG)
            maj_v = ($urandom_range(15) == 0) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                              : SAMPLE_WIDTH'(-major);
        flat_lim = (cfg.tilt_level > 0) ? cfg.tilt_level - 1 : 0;
        case (kind)
            QUAD_X_POS, QUAD_X_NEG:
            begin
                smp.accel_x = maj_v;
                smp.accel_y = min_v;
            end
            QUAD_Y_POS, QUAD_Y_NEG:
            begin
                smp.accel_x = min_v;
                smp.accel_y = maj_v;
            end
            KIND_FLAT:
            begin
                smp.accel_x = SAMPLE_WIDTH'($urandom_range(1) ? -$urandom_range(flat_lim)
                                                             : $urandom_range(flat_lim));
                smp.accel_y = SAMPLE_WIDTH'($urandom_range(1) ? -$urandom_range(flat_lim)
                                                             : $urandom_range(flat_lim));
            end
            default:
            begin
                smp.accel_x = SAMPLE_WIDTH'($urandom);
                smp.accel_y = SAMPLE_WIDTH'($urandom);
            end
        endcase
        return smp;
    endfunction

    // ------------------------------------------------------------------
    // Bus drivers
    // ------------------------------------------------------------------

    // Offers one sample and returns right after the edge that took it.
    // tvalid stays high afterwards so back-to-back items see no bubble.
    // Each idle cycle is drawn on its own, so send_idle_pct is the share
    // of idle cycles.
    task automatic send_sample(sample_t smp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            s_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({smp.accel_y, smp.accel_x, smp.now_ms});
        s_tuser  <= smp.ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        orient_due_q.push_back(qualify_sample(smp));
        items_sent++;
    endtask

    task automatic send_reading(logic [31:0] now, int x, int y, logic ok);
        sample_t smp;
        smp.now_ms  = now;
        smp.accel_x = SAMPLE_WIDTH'(x);
        smp.accel_y = SAMPLE_WIDTH'(y);
        smp.ok      = ok;
        send_sample(smp);
    endtask

    // APB write: setup cycle, then access cycle until pready, then psel drops and the
    // bus idles before it is used again.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            REG_TILT_THRESHOLD: cfg.tilt_level       = value[14:0];
            REG_AXIS_MARGIN:    cfg.axis_margin_q8   = value[9:0];
            REG_POLL_INTERVAL:  cfg.poll_interval_ms = value[15:0];
            REG_STABLE_TIME:    cfg.hold_ms          = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
        @(posedge clk);
    endtask

    // Only call while idle: every expected result already returned.
    task automatic set_config(int thr, int margin, int poll, int stable);
        write_register(REG_TILT_THRESHOLD, 32'(thr));
        write_register(REG_AXIS_MARGIN, 32'(margin));
        write_register(REG_POLL_INTERVAL, 32'(poll));
        write_register(REG_STABLE_TIME, 32'(stable));
    endtask

    // Stops offering input and waits until every result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (orient_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Runs of one held orientation with random content, mixed with flat
    // readings, noise, failed reads and early timestamps.
    task automatic run_random_phase(int count, int unsigned idle, int unsigned stall);
        int run_left;
        int kind;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        run_left       = 0;
        kind           = KIND_FLAT;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(12, 1);
                kind     = ($urandom_range(99) < 82) ? $urandom_range(3) : KIND_FLAT;
            end
            if ($urandom_range(99) < 10)
                send_sample(make_reading(KIND_NOISE, next_stamp()));
            else
                send_sample(make_reading(kind, next_stamp()));
            run_left--;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: threshold 4096, margin 1.25, poll 100 ms, stable 300 ms.
    task automatic test_directed_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_reading(32'd50, 0, 32767, 1'b1);          // earlier than poll after reset
        send_reading(32'd100, 32767, 0, 1'b0);         // failed read still takes the stamp
        send_reading(32'd150, 0, 32767, 1'b1);         // too early again
        send_reading(32'd200, 0, 32767, 1'b1);         // Y+ becomes candidate
        send_reading(32'd300, 0, 32767, 1'b1);
        send_reading(32'd500, 0, 32767, 1'b1);         // held long enough: commit
        send_reading(32'd600, -32768, 0, 1'b1);        // most negative X
        send_reading(32'd700, -32768, -32768, 1'b1);   // equal magnitudes, ambiguous
        send_reading(32'd800, -32768, 100, 1'b1);
        send_reading(32'd1100, -32768, 100, 1'b1);     // commit X-
        send_reading(32'd1200, 4095, -4095, 1'b1);     // just under threshold
        send_reading(32'd1300, 4096, 0, 1'b1);         // exactly at threshold
        send_reading(32'd1600, 4096, 0, 1'b1);
        send_reading(32'd1700, 0, -32768, 1'b1);
        send_reading(32'd2000, 5, -32768, 1'b1);
        send_reading(32'd2100, 32767, -32768, 1'b1);   // both full scale, ambiguous
        send_reading(32'hFFFF_FFC0, 0, 32767, 1'b1);
        send_reading(32'h0000_0030, 0, 32767, 1'b1);   // difference wraps through zero
        send_reading(32'h0000_0130, 0, 32767, 1'b1);   // commit across the wrap
        send_reading(32'h0000_0131, 32767, 32767, 1'b0);
        send_reading(32'h0000_0200, 0, 0, 1'b1);       // zero reading
        wait_for_results();
    endtask

    // Register extremes, margin under 1.0 included.
    task automatic test_register_extremes();
        int thr_set[4]    = '{0, 32767, 1, 16384};
        int margin_set[4] = '{0, 1023, 255, 256};
        int poll_set[4]   = '{0, 65535, 1, 10};
        int stable_set[4] = '{0, 65535, 1, 40};
        for (int i = 0; i < 4; i++)
        begin
            set_config(thr_set[i], margin_set[i], poll_set[i], stable_set[i]);
            send_idle_pct  = 20;
            recv_stall_pct = 20;
            send_reading(next_stamp(), 6000, 6000, 1'b1);       // Y wins below 1.0
            send_reading(next_stamp(), -32768, 32767, 1'b1);
            send_reading(next_stamp(), 32767, -32768, 1'b1);
            run_random_phase(30, 20, 20);
            wait_for_results();
        end
    endtask

    // Long random runs under each mix of sender gaps and receiver stalls.
    task automatic test_idle_phases();
        int unsigned idle_set[4]  = '{0, 79, 0, 34};
        int unsigned stall_set[4] = '{0, 0, 79, 34};
        for (int i = 0; i < 4; i++)
        begin
            set_config($urandom_range(12000, 500), $urandom_range(700, 256),
                       $urandom_range(80), $urandom_range(300));
            stamp_ms = $urandom;
            run_random_phase(PHASE_ITEMS, idle_set[i], stall_set[i]);
            wait_for_results();
        end
    endtask

    // Receiver holds off while the sender keeps offering: the core fills
    // and must stall its input without dropping a transaction.
    task automatic test_receiver_holdoff();
        set_config(4096, 320, 20, 60);
        holdoff_left = HOLDOFF_CYCLES;
        run_random_phase(40, 0, 0);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Checking and housekeeping processes
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
        if (err_count < PRINT_LIMIT)
            $display("%0t ns: %s mismatch on result %0d: expected %0d, got %0d",
                     $time, what, results_seen, exp_val, got_val);
        err_count++;
    endtask

    // Each result transaction against the oldest expectation.
    always @(posedge clk)
    begin : check_result
        tlt_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (orient_due_q.size() == 0)
                report_mismatch("unexpected result", 0, m_tdata);
            else
            begin
                due = orient_due_q.pop_front();
                if (m_tdata[1:0] !== due.quadrant)
                    report_mismatch("quadrant", due.quadrant, m_tdata[1:0]);
                if (m_tuser !== due.changed)
                    report_mismatch("changed flag", due.changed, m_tuser);
                if (due.changed)
                    commits_seen++;
            end
            results_seen++;
        end
    end

    // Receiver: a counted hold-off when requested, else random stalls.
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            m_tready <= 1'b0;
            holdoff_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without a transaction on any port ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        cfg.tilt_level       = TILT_THRESHOLD_RST;
        cfg.axis_margin_q8   = AXIS_MARGIN_RST;
        cfg.poll_interval_ms = POLL_INTERVAL_RST;
        cfg.hold_ms          = STABLE_TIME_RST;
        cur_quadrant         = QUAD_X_POS;
        cand_quadrant        = QUAD_X_POS;
        cand_since_ms        = '0;
        last_sample_ms       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_register_extremes();
        test_idle_phases();
        test_receiver_holdoff();

        wait_for_results();
        $display("Covered %0d samples, %0d results checked, %0d quadrant commits",
                 items_sent, results_seen, commits_seen);
        $display("Ran defaults, register extremes, four stall mixes, %0d register writes",
                 config_writes);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
